// ===== design/raw10up_pkg.sv =====
// Package for the RAW10 unpacker: beat structs, queue entry, codes and limits.
// Used by every module under design/.
`default_nettype none
package raw10up_pkg;

  localparam int unsigned CFG_W       = 14;
  localparam int unsigned MAX_DIM     = 8192;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [CFG_W-1:0] WIDTH_RST  = 14'd1920;
  localparam logic [CFG_W-1:0] HEIGHT_RST = 14'd1080;
  localparam logic [CFG_W-1:0] STRIDE_RST = 14'd0;

  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_STRIDE = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_PIXEL  = 2'd0,
    ST_STRIDE = 2'd1,
    ST_SHORT  = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
    logic       frame_end;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] pixel_value;
    logic [12:0] pixel_row;
    logic [12:0] pixel_column;
    status_e     status;
    logic        last_of_run;
  } out_beat_t;

  // One accepted byte's worth of results, waiting for the back end.
  typedef struct packed {
    status_e         status;
    logic [2:0]      count;
    logic [12:0]     row;
    logic [12:0]     col;
    logic [3:0][9:0] pix;
  } job_t;

endpackage
`default_nettype wire

// ===== design/raw10up_front.sv =====
// Front end of the RAW10 unpacker: config registers, frame/row/group counters.
// Classifies each byte and builds a queue entry; depends on raw10up_pkg.
`default_nettype none
module raw10up_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [1:0]                    cfg_idx_i,
  input  wire logic [raw10up_pkg::CFG_W-1:0] cfg_data_i,
  input  wire logic                          in_valid_i,
  input  wire raw10up_pkg::in_beat_t         in_beat_i,
  input  wire logic                          q_full_i,
  output logic                               in_ready_o,
  output logic                               push_o,
  output raw10up_pkg::job_t                  job_o
);

  localparam logic [13:0] MaxDim = 14'(raw10up_pkg::MAX_DIM);

  logic [13:0] width_q, height_q, stride_q;
  logic [31:0] held_q, held_d, cur_held;
  logic [2:0]  big_q, big_d, cur_big;
  logic [13:0] bir_q, bir_d, cur_bir;
  logic [10:0] grp_q, grp_d, cur_grp;
  logic [13:0] row_q, row_d, cur_row;
  logic        fail_q, fail_d, cur_fail;

  logic [13:0] w, h, s, row_bytes, bir_inc;
  logic [15:0] five_w;
  logic [14:0] w_p3;
  logic [12:0] groups;
  logic        active, stride_err, in_data, fire;
  logic [2:0]  npix;
  logic [12:0] col_base;
  logic [3:0][9:0] pix;

  assign in_ready_o = !q_full_i;
  assign fire       = in_valid_i && !q_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= raw10up_pkg::WIDTH_RST;
      height_q <= raw10up_pkg::HEIGHT_RST;
      stride_q <= raw10up_pkg::STRIDE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        raw10up_pkg::CFG_WIDTH:  width_q  <= cfg_data_i;
        raw10up_pkg::CFG_HEIGHT: height_q <= cfg_data_i;
        raw10up_pkg::CFG_STRIDE: stride_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    w         = (width_q > MaxDim) ? MaxDim : width_q;
    h         = (height_q > MaxDim) ? MaxDim : height_q;
    five_w    = {w, 2'b00} + {2'b00, w};
    s         = (stride_q != '0) ? stride_q : five_w[15:2];
    w_p3      = {1'b0, w} + 15'd3;
    groups    = w_p3[14:2];
    row_bytes = {groups[11:0], 2'b00} + {1'b0, groups};
  end

  always_comb begin
    cur_held = in_beat_i.frame_start ? '0 : held_q;
    cur_big  = in_beat_i.frame_start ? '0 : big_q;
    cur_bir  = in_beat_i.frame_start ? '0 : bir_q;
    cur_grp  = in_beat_i.frame_start ? '0 : grp_q;
    cur_row  = in_beat_i.frame_start ? '0 : row_q;
    cur_fail = in_beat_i.frame_start ? 1'b0 : fail_q;

    active     = !cur_fail && (s != '0) && (cur_row < h);
    stride_err = active && (row_bytes > s);
    in_data    = cur_bir < row_bytes;
    bir_inc    = cur_bir + 14'd1;
    col_base   = {cur_grp, 2'b00};

    npix = '0;
    for (int j = 0; j < 4; j++) begin
      pix[j] = {cur_held[8*j +: 8], in_beat_i.data_byte[2*j +: 2]};
      if ({1'b0, col_base + 13'(j)} < w) begin
        npix = npix + 3'd1;
      end
    end

    held_d = cur_held;
    big_d  = cur_big;
    bir_d  = cur_bir;
    grp_d  = cur_grp;
    row_d  = cur_row;
    fail_d = cur_fail;
    push_o = 1'b0;
    job_o  = '{status: raw10up_pkg::ST_PIXEL, count: npix, row: cur_row[12:0],
               col: col_base, pix: pix};

    if (stride_err) begin
      fail_d = 1'b1;
      push_o = fire;
      job_o  = '{status: raw10up_pkg::ST_STRIDE, count: 3'd1, row: '0, col: '0, pix: '0};
    end else if (active) begin
      if (in_data) begin
        if (cur_big < 3'd4) begin
          held_d[cur_big[1:0]*8 +: 8] = cur_held[cur_big[1:0]*8 +: 8] | in_beat_i.data_byte;
          big_d = cur_big + 3'd1;
        end else begin
          grp_d  = cur_grp + 11'd1;
          big_d  = '0;
          held_d = '0;
          push_o = fire && (npix != '0);
        end
      end
      bir_d = bir_inc;
      if (bir_inc >= s) begin
        bir_d  = '0;
        row_d  = cur_row + 14'd1;
        grp_d  = '0;
        big_d  = '0;
        held_d = '0;
      end
      if (in_beat_i.frame_end && (row_d < h)) begin
        fail_d = 1'b1;
        push_o = fire;
        job_o  = '{status: raw10up_pkg::ST_SHORT, count: 3'd1, row: '0, col: '0, pix: '0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      big_q  <= '0;
      bir_q  <= '0;
      grp_q  <= '0;
      row_q  <= '0;
      fail_q <= 1'b0;
    end else if (fire) begin
      held_q <= held_d;
      big_q  <= big_d;
      bir_q  <= bir_d;
      grp_q  <= grp_d;
      row_q  <= row_d;
      fail_q <= fail_d;
    end
  end

endmodule
`default_nettype wire

// ===== design/raw10up_fifo.sv =====
// Short queue of result groups between front and back of the RAW10 unpacker.
// Depends on raw10up_pkg for the entry type.
`default_nettype none
module raw10up_fifo #(
  parameter int unsigned Depth = raw10up_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire raw10up_pkg::job_t push_data_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output logic                   valid_o,
  output raw10up_pkg::job_t      data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  raw10up_pkg::job_t mem [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntFull);
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrLast) ? '0 : wr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrLast) ? '0 : rd_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

// ===== design/raw10up_back.sv =====
// Back end of the RAW10 unpacker: walks the head queue entry one result a cycle unless stalled.
// Drives the registered output beat; depends on raw10up_pkg.
`default_nettype none
module raw10up_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              q_valid_i,
  input  wire raw10up_pkg::job_t q_data_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output raw10up_pkg::out_beat_t out_beat_o
);

  logic [1:0] idx_q, idx_d;
  logic       vld_q, vld_d;
  logic       load, last;
  raw10up_pkg::out_beat_t beat_q, beat_d;

  assign load        = q_valid_i && (!vld_q || out_ready_i);
  assign last        = ({1'b0, idx_q} + 3'd1) == q_data_i.count;
  assign pop_o       = load && last;
  assign out_valid_o = vld_q;
  assign out_beat_o  = beat_q;

  always_comb begin
    idx_d  = idx_q;
    vld_d  = vld_q;
    beat_d = beat_q;
    if (load) begin
      vld_d  = 1'b1;
      idx_d  = last ? '0 : idx_q + 2'd1;
      beat_d = '{pixel_value:  {q_data_i.pix[idx_q], 6'b000000},
                 pixel_row:    q_data_i.row,
                 pixel_column: q_data_i.col + {11'd0, idx_q},
                 status:       q_data_i.status,
                 last_of_run:  last};
    end else if (out_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      vld_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    beat_q <= beat_d;
  end

endmodule
`default_nettype wire

// ===== design/raw10_packed_pixel_unpacker.sv =====
// Top level of the RAW10 unpacker: front end, result queue and back end.
// Depends on raw10up_pkg, raw10up_front, raw10up_fifo and raw10up_back.
//
//   port group   direction  handshake              payload
//   in           in         in_valid_i/in_ready_o  in_beat_i  (data_byte, frame_start/end)
//   out          out        out_valid_o/out_ready_i out_beat_o (pixel, row, column, status)
//   cfg          in         cfg_we_i               cfg_idx_i, cfg_data_i
//
// One input beat per cycle unless the queue is full; every fifth in-row byte yields up to four pixel beats.
// The back end emits one result beat per cycle unless the output stalls; each result
// passes through the result queue and then the registered output beat.
// Reset loads 1920 x 1080 with automatic stride and clears all counters.
// in_ready_o drops only when the result queue is full; output stalls back up into it.
`default_nettype none
module raw10_packed_pixel_unpacker #(
  parameter int unsigned QueueDepth = raw10up_pkg::QUEUE_DEPTH
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [1:0]                    cfg_idx_i,
  input  wire logic [raw10up_pkg::CFG_W-1:0] cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire raw10up_pkg::in_beat_t         in_beat_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output raw10up_pkg::out_beat_t             out_beat_o
);

  logic              push, full, pop, q_valid;
  raw10up_pkg::job_t push_job, head_job;

  raw10up_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_beat_i  (in_beat_i),
    .q_full_i   (full),
    .in_ready_o (in_ready_o),
    .push_o     (push),
    .job_o      (push_job)
  );

  raw10up_fifo #(.Depth(QueueDepth)) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .data_o      (head_job)
  );

  raw10up_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (head_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_beat_o  (out_beat_o)
  );

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full)
    else $error("queue push while full");

  a_err_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_beat_o.status != raw10up_pkg::ST_PIXEL)
      |-> out_beat_o.last_of_run && (out_beat_o.pixel_value == '0))
    else $error("error beat not alone or carries a value");

  a_run_continues : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_beat_o.last_of_run |=> out_valid_o)
    else $error("gap inside a run of result beats");

  a_pop_has_data : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q_valid)
    else $error("queue pop while empty");

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Testbench for raw10_packed_pixel_unpacker: directed and random RAW10 byte streams.
// A scoreboard class unpacks each accepted byte in step with the block and checks every
// result beat in order. Depends on raw10up_pkg and the modules under design/.
module testbench;
  import raw10up_pkg::*;

  localparam int unsigned MAX_STRIDE   = 16383;
  localparam int unsigned RANDOM_ITEMS = 220;
  localparam int unsigned SEGMENTS     = 8;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned STALL_LIMIT  = 2000;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  class raw10_scoreboard;
    logic [13:0] reg_width;
    logic [13:0] reg_height;
    logic [13:0] reg_stride;
    logic [31:0] held_bytes;
    logic [2:0]  byte_in_group;
    logic [13:0] byte_in_row;
    logic [10:0] group_index;
    logic [13:0] row_index;
    bit          frame_failed;
    out_beat_t   pending_beats[$];
    int unsigned errors;
    int unsigned pixels;
    int unsigned stride_errors;
    int unsigned short_frames;

    function new();
      reg_width     = WIDTH_RST;
      reg_height    = HEIGHT_RST;
      reg_stride    = STRIDE_RST;
      errors        = 0;
      pixels        = 0;
      stride_errors = 0;
      short_frames  = 0;
      clear_counters();
    endfunction

    function void clear_counters();
      held_bytes    = '0;
      byte_in_group = '0;
      byte_in_row   = '0;
      group_index   = '0;
      row_index     = '0;
      frame_failed  = 1'b0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [13:0] value);
      case (idx)
        CFG_WIDTH:  reg_width = value;
        CFG_HEIGHT: reg_height = value;
        CFG_STRIDE: reg_stride = value;
        default: ;
      endcase
    endfunction

    function int unsigned eff_width();
      return (reg_width > MAX_DIM) ? MAX_DIM : reg_width;
    endfunction

    function int unsigned eff_height();
      return (reg_height > MAX_DIM) ? MAX_DIM : reg_height;
    endfunction

    function int unsigned eff_stride();
      int unsigned s;
      s = (reg_stride != 0) ? reg_stride : (eff_width() * 10) / 8;
      return (s > MAX_STRIDE) ? MAX_STRIDE : s;
    endfunction

    function int unsigned frame_bytes();
      return eff_stride() * eff_height();
    endfunction

    function out_beat_t flag_beat(status_e st);
      out_beat_t beat;
      beat = '0;
      beat.status = st;
      beat.last_of_run = 1'b1;
      return beat;
    endfunction

    function void take_byte(in_beat_t b);
      int unsigned w;
      int unsigned h;
      int unsigned s;
      int unsigned rb;
      int unsigned col;
      int          j;
      out_beat_t   pix[$];
      out_beat_t   beat;
      w  = eff_width();
      h  = eff_height();
      s  = eff_stride();
      rb = ((w + 3) / 4) * 5;
      if (b.frame_start) clear_counters();
      if (frame_failed || s == 0 || row_index >= h) return;
      if (rb > s) begin
        frame_failed = 1'b1;
        pending_beats.push_back(flag_beat(ST_STRIDE));
        return;
      end
      if (byte_in_row < rb) begin
        if (byte_in_group < 4) begin
          held_bytes[8*byte_in_group +: 8] = b.data_byte;
          byte_in_group++;
        end else begin
          for (j = 0; j < 4; j++) begin
            col = group_index * 4 + j;
            if (col < w) begin
              beat.pixel_value  = {held_bytes[8*j +: 8], b.data_byte[2*j +: 2], 6'd0};
              beat.pixel_row    = row_index[12:0];
              beat.pixel_column = col[12:0];
              beat.status       = ST_PIXEL;
              beat.last_of_run  = 1'b0;
              pix.push_back(beat);
            end
          end
          group_index++;
          byte_in_group = '0;
          held_bytes    = '0;
        end
      end
      byte_in_row++;
      if (byte_in_row >= s) begin
        byte_in_row   = '0;
        row_index++;
        group_index   = '0;
        byte_in_group = '0;
        held_bytes    = '0;
      end
      if (b.frame_end && row_index < h) begin
        frame_failed = 1'b1;
        pending_beats.push_back(flag_beat(ST_SHORT));
        return;
      end
      foreach (pix[k]) begin
        beat = pix[k];
        beat.last_of_run = (k == pix.size() - 1);
        pending_beats.push_back(beat);
      end
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("MISMATCH: %s", what);
    endtask

    task check_beat(out_beat_t got);
      out_beat_t want;
      if (pending_beats.size() == 0) begin
        report_mismatch($sformatf("result beat with none pending: value %0d row %0d col %0d st %0d",
                                  got.pixel_value, got.pixel_row, got.pixel_column, got.status));
        return;
      end
      want = pending_beats.pop_front();
      if (got.pixel_value !== want.pixel_value)
        report_mismatch($sformatf("pixel_value %0d, want %0d (row %0d col %0d)", got.pixel_value,
                                  want.pixel_value, want.pixel_row, want.pixel_column));
      if (got.pixel_row !== want.pixel_row)
        report_mismatch($sformatf("pixel_row %0d, want %0d", got.pixel_row, want.pixel_row));
      if (got.pixel_column !== want.pixel_column)
        report_mismatch($sformatf("pixel_column %0d, want %0d", got.pixel_column,
                                  want.pixel_column));
      if (got.status !== want.status)
        report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.last_of_run !== want.last_of_run)
        report_mismatch($sformatf("last_of_run %0b, want %0b (row %0d col %0d)", got.last_of_run,
                                  want.last_of_run, want.pixel_row, want.pixel_column));
      case (want.status)
        ST_PIXEL:  pixels++;
        ST_STRIDE: stride_errors++;
        default:   short_frames++;
      endcase
    endtask
  endclass

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             cfg_we_i    = 1'b0;
  logic [1:0]       cfg_idx_i   = '0;
  logic [CFG_W-1:0] cfg_data_i  = '0;
  logic             in_valid_i  = 1'b0;
  logic             in_ready_o;
  in_beat_t         in_beat_i   = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  out_beat_t        out_beat_o;

  idle_mode_e      idle_mode      = IDLE_NONE;
  int unsigned     beats_sent     = 0;
  int unsigned     stall_cycles   = 0;
  int unsigned     settings_used  = 0;
  raw10_scoreboard sb             = new();

  raw10_packed_pixel_unpacker u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_beat_i   (in_beat_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_beat_o  (out_beat_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int unsigned idle_pct(bit receiver);
    case (idle_mode)
      IDLE_SENDER:   return receiver ? 0 : 69;
      IDLE_RECEIVER: return receiver ? 69 : 0;
      IDLE_BOTH:     return 20;
      default:       return 0;
    endcase
  endfunction

  always @(negedge clk_i) begin
    out_ready_i = ($urandom_range(0, 99) >= idle_pct(1'b1));
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.take_byte(in_beat_i);
      if (out_valid_o && out_ready_i) sb.check_beat(out_beat_o);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no beat accepted for %0d cycles", STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic send_byte(logic [7:0] data, bit start, bit stop);
    in_beat_t beat;
    beat.data_byte   = data;
    beat.frame_start = start;
    beat.frame_end   = stop;
    while ($urandom_range(0, 99) < idle_pct(1'b0)) @(negedge clk_i);
    in_valid_i = 1'b1;
    in_beat_i  = beat;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    beats_sent++;
  endtask

  task automatic send_frame(int unsigned n, bit with_start, bit with_end);
    for (int unsigned i = 0; i < n; i++)
      send_byte(8'($urandom_range(0, 255)), with_start && i == 0, with_end && i == n - 1);
  endtask

  task automatic write_reg(cfg_idx_e idx, int unsigned value);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = value[CFG_W-1:0];
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.set_reg(idx, value[CFG_W-1:0]);
  endtask

  task automatic drain();
    while (sb.pending_beats.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic apply_settings(int unsigned w, int unsigned h, int unsigned s);
    drain();
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    write_reg(CFG_STRIDE, s);
    settings_used++;
  endtask

  task automatic random_segment(int unsigned quota);
    int unsigned w;
    int unsigned rb;
    int unsigned s;
    int unsigned len;
    int unsigned kind;
    int unsigned first;
    w    = $urandom_range(1, 16);
    rb   = ((w + 3) / 4) * 5;
    kind = $urandom_range(0, 9);
    if (kind < 2) begin
      w = 4 * $urandom_range(1, 4);
      s = 0;
    end else if (kind == 2) begin
      s = rb - $urandom_range(1, 4);
    end else begin
      s = rb + $urandom_range(0, 3);
    end
    apply_settings(w, $urandom_range(1, 3), s);
    len   = sb.frame_bytes();
    first = beats_sent;
    while (beats_sent - first < quota) begin
      kind = $urandom_range(0, 9);
      case (kind)
        5: send_frame($urandom_range(1, len), 1'b1, 1'b1);
        6: begin
          send_frame(len, 1'b1, 1'b1);
          send_frame($urandom_range(1, 3), 1'b0, $urandom_range(0, 1) == 1);
        end
        7: repeat ($urandom_range(1, 4))
          send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                    $urandom_range(0, 3) == 0);
        8: send_frame($urandom_range(1, len), 1'b1, 1'b0);
        9: send_frame(len, 1'b0, 1'b1);
        default: send_frame(len, 1'b1, 1'b1);
      endcase
    end
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset settings, no frame_start: one group, then an early frame end, then a dropped beat
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hAA, 1'b0, 1'b0);
    send_byte(8'h55, 1'b0, 1'b0);
    send_byte(8'h93, 1'b0, 1'b0);
    send_byte(8'h3C, 1'b0, 1'b1);
    send_byte(8'h12, 1'b0, 1'b0);

    // automatic stride too small for one pixel
    apply_settings(1, 1, 0);
    send_byte(8'h5A, 1'b1, 1'b0);
    send_byte(8'hA5, 1'b0, 1'b1);

    // full two-row frame, then a beat past its end
    apply_settings(4, 2, 0);
    send_frame(10, 1'b1, 1'b1);
    send_byte(8'h77, 1'b0, 1'b1);

    // saturated registers: one group, then a restart that ends short
    apply_settings(16383, 16383, 16383);
    send_byte(8'hC3, 1'b1, 1'b0);
    send_frame(4, 1'b0, 1'b0);
    send_byte(8'h0F, 1'b1, 1'b1);

    // spread what is left of the beat budget over the segments
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      idle_mode = idle_mode_e'(seg % 4);
      random_segment((beats_sent + SEGMENTS - seg < RANDOM_ITEMS) ?
                     (RANDOM_ITEMS - beats_sent) / (SEGMENTS - seg) : 1);
    end
    drain();

    $display("covered %0d input beats across %0d register settings and four idle patterns",
             beats_sent, settings_used);
    $display("checked %0d pixels, %0d stride-too-small results, %0d short-frame results",
             sb.pixels, sb.stride_errors, sb.short_frames);
    if (sb.errors == 0 && sb.pending_beats.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
